/* sv/sorted_timer_event_queue_macros.svh */
// Assertion macros for the sorted timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Implication that must hold at every clock edge outside reset.
`define STQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stq assertion failed");
// Condition that must never be true outside reset.
`define STQ_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("stq assertion failed");
`else
`define STQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* sv/stq_pkg.sv */
// Package with the types and codes of the sorted timer event queue.
`timescale 1ns / 1ps
package stq_pkg;
	localparam int DUE_BITS = 32;
	localparam int ID_PORT_BITS = 16;

	typedef enum logic [1:0] {
		ST_FIRED   = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_TK_RD,
		S_TK_CMP,
		S_FLUSH,
		S_DONE
	} state_t;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;
endpackage

/* sv/stq_ram.sv */
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* sv/sorted_timer_event_queue.sv */
// Sorted timer event queue: circular buffer in one RAM kept ordered by due cycle.
// Insert: entries are examined from the tail (RAM read, then compare), each later one moved
// one place back, then the result is loaded; an empty or full queue needs no examination.
// Tick: each examined head entry is read from RAM then compared, one result per fired entry.
// One item is taken at a time; output stalls hold the sequencer. Reset (arst_n low) empties
// the queue and drops any pending result; RAM is not cleared.
`timescale 1ns / 1ps
`include "sorted_timer_event_queue_macros.svh"
module sorted_timer_event_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // cycle [31:0], event_id [47:32]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // status [1:0], fired_id [17:2], zero fill [23:18]
	output logic        m_tlast
);
	import stq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IDW = (ID_BITS < ID_PORT_BITS) ? ID_BITS : ID_PORT_BITS;
	localparam int EW = DUE_BITS + IDW;

	state_t state_q, state_d;
	logic [AW-1:0] hd_q, hd_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] j_q, j_d;
	logic [DUE_BITS-1:0] cyc_q;
	logic [IDW-1:0] id_q;
	logic [IDW-1:0] pend_q, pend_d;
	logic pend_v_q, pend_v_d;
	status_t res_q, res_d;
	logic out_valid_q;
	status_t out_status_q;
	logic [IDW-1:0] out_id_q;
	logic out_last_q;

	logic ld;
	status_t ld_status;
	logic [IDW-1:0] ld_id;
	logic ld_last;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data, rd_data;
	logic [DUE_BITS-1:0] rd_due;
	logic [IDW-1:0] rd_id;
	logic accept, out_free, full;
	logic [DUE_BITS-1:0] in_cyc;
	logic [IDW-1:0] in_id;

	// map a position in the queue to a RAM address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW:0] off);
		logic [AW:0] s;
		s = {1'b0, hd} + off;
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign in_cyc = s_tdata[31:0];
	assign in_id = s_tdata[32 +: IDW];
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full = (cnt_q == CW'(QUEUE_DEPTH));
	assign rd_due = rd_data[EW-1:IDW];
	assign rd_id = rd_data[IDW-1:0];

	stq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	// sequencer: next state, RAM accesses and result loads
	always_comb begin
		state_d = state_q;
		hd_d = hd_q;
		cnt_d = cnt_q;
		j_d = j_q;
		pend_d = pend_q;
		pend_v_d = pend_v_q;
		res_d = res_q;
		ld = 1'b0;
		ld_status = ST_FIRED;
		ld_id = pend_q;
		ld_last = 1'b1;
		rd_en = 1'b0;
		rd_addr = phys(hd_q, (AW+1)'(j_q));
		wr_en = 1'b0;
		wr_addr = phys(hd_q, '0);
		wr_data = {cyc_q, id_q};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == FUNC_INSERT) begin
						if (full) begin
							res_d = ST_DROPPED;
							state_d = S_DONE;
						end else if (cnt_q == '0) begin
							wr_en = 1'b1;
							wr_data = {in_cyc, in_id};
							cnt_d = cnt_q + 1'b1;
							res_d = ST_INSERTED;
							state_d = S_DONE;
						end else begin
							j_d = AW'(cnt_q - 1'b1);
							state_d = S_INS_RD;
						end
					end else if (cnt_q != '0) begin
						state_d = S_TK_RD;
					end
				end
			end
			S_INS_RD: begin
				rd_en = 1'b1;
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				// move a later entry one place back, or drop the new one in behind it
				wr_en = 1'b1;
				wr_addr = phys(hd_q, (AW+1)'(j_q) + 1'b1);
				if (rd_due > cyc_q) begin
					wr_data = rd_data;
					if (j_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						j_d = j_q - 1'b1;
						state_d = S_INS_RD;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
					res_d = ST_INSERTED;
					state_d = S_DONE;
				end
			end
			S_INS_PUT: begin
				wr_en = 1'b1;
				cnt_d = cnt_q + 1'b1;
				res_d = ST_INSERTED;
				state_d = S_DONE;
			end
			S_TK_RD: begin
				rd_en = 1'b1;
				rd_addr = hd_q;
				state_d = S_TK_CMP;
			end
			S_TK_CMP: begin
				if (rd_due == cyc_q) begin
					// pop the head; the previous fired entry goes out unmarked
					if (!pend_v_q || out_free) begin
						ld = pend_v_q;
						ld_last = 1'b0;
						pend_d = rd_id;
						pend_v_d = 1'b1;
						hd_d = phys(hd_q, (AW+1)'(1));
						cnt_d = cnt_q - 1'b1;
						state_d = (cnt_q == CW'(1)) ? S_FLUSH : S_TK_RD;
					end
				end else begin
					state_d = pend_v_q ? S_FLUSH : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					ld = 1'b1;
					pend_v_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ld = 1'b1;
					ld_status = res_q;
					ld_id = id_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hd_q <= '0;
			cnt_q <= '0;
			pend_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hd_q <= hd_d;
			cnt_q <= cnt_d;
			pend_v_q <= pend_v_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		j_q <= j_d;
		pend_q <= pend_d;
		res_q <= res_d;
		if (accept) begin
			cyc_q <= in_cyc;
			id_q <= in_id;
		end
		if (ld) begin
			out_status_q <= ld_status;
			out_id_q <= ld_id;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, ID_PORT_BITS'(out_id_q), out_status_q};
	assign m_tlast = out_last_q;

	`STQ_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(QUEUE_DEPTH))
	`STQ_ASSERT_IMPL(a_idle_no_pend, clk, arst_n, state_q == S_IDLE, !pend_v_q)
	`STQ_ASSERT_IMPL(a_drop_keeps, clk, arst_n, accept && s_tuser == FUNC_INSERT && full, ##1 $stable(cnt_q) && $stable(hd_q))
	`STQ_ASSERT_IMPL(a_status_code, clk, arst_n, out_valid_q, out_status_q == ST_FIRED || out_status_q == ST_INSERTED || out_status_q == ST_DROPPED)
endmodule

/* tb/sv/tb_sorted_timer_event_queue.sv */
// Testbench for the sorted timer event queue: directed and random inserts and ticks.
`timescale 1ns / 1ps
module tb_sorted_timer_event_queue;
	import stq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 130;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        func;
		logic [31:0] cycle;
		logic [15:0] event_id;
	} op_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] id;
		logic        last;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tlast;

	op_item_t pending_ops[$];
	outcome_t expected_outcomes[$];
	logic [31:0] sched_due[$];
	logic [15:0] sched_handle[$];
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	sorted_timer_event_queue #(.QUEUE_DEPTH(DEPTH), .ID_BITS(16)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Append one expected result transfer
	function automatic void expect_outcome(input status_t status, input logic [15:0] id,
			input logic last);
		outcome_t o;
		o.status = status;
		o.id = id;
		o.last = last;
		expected_outcomes = {expected_outcomes, o};
	endfunction

	// Update the shadow schedule and queue the outcomes for one accepted transfer
	function automatic void predict_schedule(input op_item_t op);
		int pos;
		int fired;
		if (op.func == FUNC_INSERT) begin
			if (sched_due.size() >= DEPTH) begin
				expect_outcome(ST_DROPPED, op.event_id, 1'b1);
				return;
			end
			pos = sched_due.size();
			for (int j = 0; j < sched_due.size(); j++)
				if (sched_due[j] > op.cycle) begin
					pos = j;
					break;
				end
			sched_due.insert(pos, op.cycle);
			sched_handle.insert(pos, op.event_id);
			expect_outcome(ST_INSERTED, op.event_id, 1'b1);
		end else begin
			fired = 0;
			while (fired < sched_due.size() && sched_due[fired] == op.cycle)
				fired++;
			for (int j = 0; j < fired; j++) begin
				expect_outcome(ST_FIRED, sched_handle[0], j == fired - 1);
				void'(sched_due.pop_front());
				void'(sched_handle.pop_front());
			end
		end
	endfunction

	function automatic void add_op(input logic func, input logic [31:0] cyc,
			input logic [15:0] id);
		op_item_t op;
		op.func = func;
		op.cycle = cyc;
		op.event_id = id;
		pending_ops = {pending_ops, op};
	endfunction

	// Drive pending operations in bursts separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_schedule(op_item_t'({s_tuser, s_tdata[31:0], s_tdata[47:32]}));
				void'(pending_ops.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_ops[0].func;
					s_tdata <= {pending_ops[0].event_id, pending_ops[0].cycle};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side on its own pattern and check every transfer
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			cycle_count++;
			if (m_tvalid && m_tready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_outcomes.pop_front();
					if (m_tdata[1:0] != want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							m_tdata[1:0], want.status));
					if (m_tdata[17:2] != want.id)
						report_mismatch($sformatf("id %h, expected %h", m_tdata[17:2], want.id));
					if (m_tlast != want.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
				end
			end
			if ((cycle_count / 64) % 4 == 3)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 2) != 0);
			if (cycle_count > CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Fill the queue of operations: directed cases first, then random sequences
	initial begin
		logic [31:0] base;
		int n;
		int k;
		// empty tick, extremes of the fields
		add_op(FUNC_TICK, 32'd0, 16'hFFFF);
		add_op(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		add_op(FUNC_INSERT, 32'd0, 16'h0000);
		add_op(FUNC_INSERT, 32'd0, 16'h5A5A);
		add_op(FUNC_INSERT, 32'd7, 16'hA5A5);
		// overdue head blocks later entries
		add_op(FUNC_TICK, 32'd7, 16'h0);
		// two equal due cycles fire in arrival order
		add_op(FUNC_TICK, 32'd0, 16'h0);
		add_op(FUNC_TICK, 32'd7, 16'h0);
		add_op(FUNC_TICK, 32'hFFFF_FFFF, 16'h0);
		// fill to capacity, then drop
		for (int j = 0; j < DEPTH; j++)
			add_op(FUNC_INSERT, 32'd100, 16'(j + 1));
		add_op(FUNC_INSERT, 32'd50, 16'hBEEF);
		add_op(FUNC_TICK, 32'd100, 16'h0);

		k = 0;
		while (k < RANDOM_ITEMS) begin
			base = $urandom();
			n = $urandom_range(1, 18);
			for (int j = 0; j < n; j++) begin
				add_op(FUNC_INSERT, ($urandom_range(0, 9) == 0) ? $urandom() :
					base + $urandom_range(0, 3), 16'($urandom()));
				k++;
			end
			// ticks walk forward so queued entries actually fire
			for (int t = 0; t < 4; t++) begin
				add_op(FUNC_TICK, ($urandom_range(0, 7) == 0) ? $urandom() : base + t,
					16'($urandom()));
				k++;
			end
		end
		// drain whatever remains fireable
		for (int t = 0; t < 4; t++)
			add_op(FUNC_TICK, base + t, 16'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0);
		wait (expected_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* sorted_timer_event_queue.f */
+incdir+sv
sv/stq_pkg.sv
sv/stq_ram.sv
sv/sorted_timer_event_queue.sv
tb/sv/tb_sorted_timer_event_queue.sv
